// File: design/ggpc_pkg.sv
package ggpc_pkg;

	localparam int FRAC_BITS_DEF    = 10;
	localparam int CORDIC_STEPS_DEF = 14;
	localparam int MAX_STEPS        = 24;
	localparam int SQRT_STEPS       = 17;
	localparam int ITER_W           = $clog2(MAX_STEPS);

	localparam int POS_W  = 16;
	localparam int HD_W   = 13;
	localparam int CMD_W  = 16;
	localparam int TOL_W  = 15;
	localparam int DIFF_W = 17;
	localparam int SQ_W   = 33;
	localparam int CW     = 39;
	localparam int ZW     = 33;
	localparam int TW     = 34;

	localparam logic signed [TW-1:0] PI_Q30      = 34'sd3373258724;
	localparam logic signed [TW-1:0] PI_HALF_Q30 = 34'sd1686629362;

	typedef enum logic [1:0] {
		PH_DRIVE = 2'd0,
		PH_ALIGN = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_GOAL_X = 2'd0,
		REG_GOAL_Y = 2'd1,
		REG_TOL    = 2'd2,
		REG_THR    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQT,
		ST_ITER,
		ST_ROUND,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              load;
		logic              sq_x;
		logic              sq_y;
		logic              sq_t;
		logic              iter;
		logic [ITER_W-1:0] idx;
		logic              round;
		logic              finish;
	} dp_cmd_t;

	typedef struct packed {
		logic drive;
		logic out_full;
	} dp_stat_t;

	// atan(2^-i) in Q30
	function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [CMD_W-1:0] sat16(input logic signed [TW+2:0] v);
		logic signed [TW+2:0] hi;
		logic signed [TW+2:0] lo;
		logic signed [CMD_W-1:0] r;
		hi = (TW+3)'(32767);
		lo = (TW+3)'(-32768);
		if (v > hi) begin
			r = 16'sh7fff;
		end else if (v < lo) begin
			r = 16'sh8000;
		end else begin
			r = v[CMD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: design/ggpc_ctrl.sv
module ggpc_ctrl import ggpc_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam int CORDIC_N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int ITER_N   = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_N - 1);

	state_t            state_q;
	state_t            state_d;
	logic [ITER_W-1:0] cnt_q;
	logic              fin_ok;

	assign fin_ok = !stat.out_full || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQT) begin
				cnt_q <= '0;
			end else if (state_q == ST_ITER) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.drive ? ST_SQX : ST_FINISH;
				end
			end
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_SQT;
			ST_SQT:   state_d = ST_ITER;
			ST_ITER: begin
				if (cnt_q == ITER_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_FINISH;
			ST_FINISH: begin
				if (fin_ok) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd        = '0;
		cmd.idx    = cnt_q;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.sq_x   = (state_q == ST_SQX);
		cmd.sq_y   = (state_q == ST_SQY);
		cmd.sq_t   = (state_q == ST_SQT);
		cmd.iter   = (state_q == ST_ITER);
		cmd.round  = (state_q == ST_ROUND);
		cmd.finish = (state_q == ST_FINISH) && fin_ok;
	end

endmodule

// File: design/ggpc_dp.sv
module ggpc_dp import ggpc_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [1:0]              cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic signed [POS_W-1:0] pose_x,
	input  logic signed [POS_W-1:0] pose_y,
	input  logic signed [HD_W-1:0]  pose_heading,
	input  logic                    out_ready,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	output logic                    out_valid,
	output logic signed [CMD_W-1:0] linear_cmd,
	output logic signed [CMD_W-1:0] angular_cmd,
	output logic [1:0]              phase_now
);

	localparam int CORDIC_N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int RND_S    = 30 - FRAC_BITS;
	localparam logic signed [TW-1:0]    RND_HALF  = TW'(2 ** (RND_S - 1));
	localparam logic signed [CMD_W-1:0] SPIN      =
		CMD_W'((FRAC_BITS >= 13) ? 32767 : (4 << FRAC_BITS));
	localparam logic [ITER_W:0]  CORDIC_NV = (ITER_W+1)'(CORDIC_N);
	localparam logic [ITER_W:0]  SQRT_NV   = (ITER_W+1)'(SQRT_STEPS);
	localparam logic [SQ_W-1:0]  SQ_B0     = SQ_W'(1) << (2 * (SQRT_STEPS - 1));
	localparam logic [SQ_W-1:0]  LIN_MAX   = SQ_W'(32767);

	// configuration and phase
	logic signed [POS_W-1:0] goal_x_q;
	logic signed [POS_W-1:0] goal_y_q;
	logic [TOL_W-1:0]        tol_q;
	logic signed [POS_W-1:0] thr_q;
	phase_t                  phase_q;

	// working registers
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [HD_W-1:0]   hd_q;
	logic [SQ_W-1:0]          acc_q;
	logic [SQ_W-1:0]          tsq_q;
	logic signed [CW-1:0]     cx_q;
	logic signed [CW-1:0]     cy_q;
	logic signed [ZW-1:0]     cz_q;
	logic [SQ_W-1:0]          sq_n_q;
	logic [SQ_W:0]            sq_r_q;
	logic [SQ_W-1:0]          sq_b_q;
	logic signed [TW-1:0]     bear_q;

	// result register
	logic                    out_valid_q;
	logic signed [CMD_W-1:0] lin_q;
	logic signed [CMD_W-1:0] ang_q;
	phase_t                  ph_q;

	logic signed [DIFF_W-1:0]   mul_a;
	logic signed [2*DIFF_W-1:0] mul_p;
	logic signed [DIFF_W-1:0]   abs_dx;
	logic signed [DIFF_W-1:0]   abs_dy;
	logic signed [CW-1:0]       xs;
	logic signed [CW-1:0]       ys;
	logic signed [ZW-1:0]       at;
	logic [SQ_W:0]              sq_trial;
	logic signed [TW-1:0]       ang_a;
	logic signed [TW-1:0]       ang_t;
	logic signed [TW:0]         ang_diff;
	logic signed [TW+2:0]       ang_x4;
	logic [SQ_W:0]              lin_half;
	logic signed [CMD_W-1:0]    lin_sat;
	logic                       near;
	logic signed [CMD_W-1:0]    lin_d;
	logic signed [CMD_W-1:0]    ang_d;
	phase_t                     ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			tol_q    <= TOL_W'(10);
			thr_q    <= POS_W'(102);
			phase_q  <= PH_DRIVE;
		end else begin
			if (cmd.finish) begin
				phase_q <= ph_d;
			end
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_GOAL_X: begin
						goal_x_q <= cfg_data;
						phase_q  <= PH_DRIVE;
					end
					REG_GOAL_Y: begin
						goal_y_q <= cfg_data;
						phase_q  <= PH_DRIVE;
					end
					REG_TOL: tol_q <= cfg_data[TOL_W-1:0];
					REG_THR: thr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		priority if (cmd.sq_x) begin
			mul_a = dx_q;
		end else if (cmd.sq_y) begin
			mul_a = dy_q;
		end else begin
			mul_a = signed'({2'b00, tol_q});
		end
		mul_p = mul_a * mul_a;

		abs_dx = dx_q[DIFF_W-1] ? -dx_q : dx_q;
		abs_dy = dy_q[DIFF_W-1] ? -dy_q : dy_q;

		xs = cx_q >>> cmd.idx;
		ys = cy_q >>> cmd.idx;
		at = signed'(ZW'(atan_q30(cmd.idx)));

		sq_trial = sq_r_q + {1'b0, sq_b_q};

		priority if (dy_q == '0) begin
			ang_a = '0;
		end else if (dx_q == '0) begin
			ang_a = PI_HALF_Q30;
		end else begin
			ang_a = TW'(cz_q);
		end
		ang_t = dx_q[DIFF_W-1] ? (PI_Q30 - ang_a) : ang_a;
		if (dy_q[DIFF_W-1]) begin
			ang_t = -ang_t;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= DIFF_W'(goal_x_q) - DIFF_W'(pose_x);
			dy_q <= DIFF_W'(goal_y_q) - DIFF_W'(pose_y);
			hd_q <= pose_heading;
		end
		if (cmd.sq_x) begin
			acc_q <= SQ_W'(mul_p);
			cx_q  <= CW'(abs_dx) <<< 20;
			cy_q  <= CW'(abs_dy) <<< 20;
			cz_q  <= '0;
		end
		if (cmd.sq_y) begin
			acc_q <= acc_q + SQ_W'(mul_p);
		end
		if (cmd.sq_t) begin
			tsq_q  <= SQ_W'(mul_p);
			sq_n_q <= acc_q;
			sq_r_q <= '0;
			sq_b_q <= SQ_B0;
		end
		if (cmd.iter && ({1'b0, cmd.idx} < CORDIC_NV)) begin
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end
		end
		if (cmd.iter && ({1'b0, cmd.idx} < SQRT_NV)) begin
			if ({1'b0, sq_n_q} >= sq_trial) begin
				sq_n_q <= sq_n_q - sq_trial[SQ_W-1:0];
				sq_r_q <= (sq_r_q >> 1) + {1'b0, sq_b_q};
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_b_q <= sq_b_q >> 2;
		end
		if (cmd.round) begin
			bear_q <= (ang_t + RND_HALF) >>> RND_S;
		end
		if (cmd.finish) begin
			lin_q <= lin_d;
			ang_q <= ang_d;
			ph_q  <= ph_d;
		end
	end

	always_comb begin
		near     = (acc_q <= tsq_q);
		lin_half = sq_r_q >> 1;
		lin_sat  = (lin_half > {1'b0, LIN_MAX}) ? 16'sh7fff : lin_half[CMD_W-1:0];
		ang_diff = (TW+1)'(bear_q) - (TW+1)'(hd_q);
		ang_x4   = (TW+3)'(ang_diff) <<< 2;
		lin_d    = '0;
		ang_d    = '0;
		ph_d     = PH_DONE;
		unique case (phase_q)
			PH_DRIVE: begin
				if (near) begin
					ang_d = SPIN;
					ph_d  = PH_ALIGN;
				end else begin
					lin_d = lin_sat;
					ang_d = sat16(ang_x4);
					ph_d  = PH_DRIVE;
				end
			end
			PH_ALIGN: begin
				if (POS_W'(hd_q) <= thr_q) begin
					ph_d = PH_DONE;
				end else begin
					ang_d = SPIN;
					ph_d  = PH_ALIGN;
				end
			end
			default: ph_d = PH_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.drive    = (phase_q == PH_DRIVE);
	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign linear_cmd    = lin_q;
	assign angular_cmd   = ang_q;
	assign phase_now     = ph_q;

endmodule

// File: design/go_to_goal_pose_controller_core.sv
// Drive phase: load, SQX, SQY, SQT, the shared sqrt/CORDIC iteration loop, ROUND and FINISH
// from input transaction to result; align/done phase goes from load straight to FINISH.
// Flow: one item in flight; next input transaction in the cycle after the result is
// registered, in drive phase and in align/done phase alike.
// A result held by out_ready stalls the last step, and with it the input.
// Reset: arst_n asynchronous, active low; goal 0, tolerance 10, threshold 102, drive phase.
module go_to_goal_pose_controller_core import ggpc_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] pose_x,
	input  logic signed [POS_W-1:0] pose_y,
	input  logic signed [HD_W-1:0]  pose_heading,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CMD_W-1:0] linear_cmd,
	output logic signed [CMD_W-1:0] angular_cmd,
	output logic [1:0]              phase_now
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ggpc_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ggpc_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pose_x      (pose_x),
		.pose_y      (pose_y),
		.pose_heading(pose_heading),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.phase_now   (phase_now)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_done_is_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (phase_now == 2'(PH_DONE))) |-> (linear_cmd == '0 && angular_cmd == '0))
		else $error("nonzero command in done phase");

	a_speed_only_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (linear_cmd != '0)) |-> (phase_now == 2'(PH_DRIVE)))
		else $error("forward speed outside drive phase");

	a_finish_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!stat.out_full || out_ready))
		else $error("result overwritten before transaction");
`endif

endmodule

// File: tb/pose_cmd_checker.sv
module pose_cmd_checker import ggpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [POS_W-1:0] pose_x,
	input  logic signed [POS_W-1:0] pose_y,
	input  logic signed [HD_W-1:0]  pose_heading,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [CMD_W-1:0] linear_cmd,
	input  logic signed [CMD_W-1:0] angular_cmd,
	input  logic [1:0]              phase_now,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC       = 10;
	localparam int     ROUND_SH   = 30 - FRAC;
	localparam int     ANGLE_STEPS = 14;
	localparam int     PRESHIFT   = 20;
	localparam longint PI_FIX     = 64'sd3373258724;
	localparam logic signed [CMD_W-1:0] SPIN_RATE = 16'sd4096;

	typedef struct packed {
		logic signed [CMD_W-1:0] lin;
		logic signed [CMD_W-1:0] ang;
		phase_t                  ph;
	} cmd_t;

	logic signed [POS_W-1:0] goal_x_q;
	logic signed [POS_W-1:0] goal_y_q;
	logic [TOL_W-1:0]        tol_q;
	logic signed [POS_W-1:0] thr_q;
	phase_t                  phase_q;
	cmd_t                    cmd_expected[$];
	cmd_t                    want;
	cmd_t                    fresh;
	longint                  atan_step [0:ANGLE_STEPS-1];

	initial begin
		fail_count = 0;
		atan_step = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072};
	end

	function automatic logic signed [CMD_W-1:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[CMD_W-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// vectoring rotation, both inputs positive, angle in Q30
	function automatic longint first_quadrant_angle(input longint ax, input longint ay);
		longint xv;
		longint yv;
		longint zv;
		longint xs;
		longint ys;
		int     i;
		xv = ax <<< PRESHIFT;
		yv = ay <<< PRESHIFT;
		zv = 0;
		for (i = 0; i < ANGLE_STEPS; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv >= 0) begin
				xv += ys;
				yv -= xs;
				zv += atan_step[i];
			end else begin
				xv -= ys;
				yv += xs;
				zv -= atan_step[i];
			end
		end
		return zv;
	endfunction

	function automatic longint goal_bearing(input longint dx, input longint dy);
		longint a;
		longint t;
		if (dy == 0) begin
			a = 0;
		end else if (dx == 0) begin
			a = PI_FIX / 2;
		end else begin
			a = first_quadrant_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
		end
		t = (dx >= 0) ? a : PI_FIX - a;
		if (dy < 0) begin
			t = -t;
		end
		return (t + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
	endfunction

	function automatic cmd_t next_command(input phase_t ph, input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py, input logic signed [HD_W-1:0] hd);
		cmd_t            c;
		longint          dx;
		longint          dy;
		longint          hdl;
		longint unsigned d2;
		longint unsigned tsq;
		longint unsigned half;
		c.lin = '0;
		c.ang = '0;
		c.ph  = PH_DONE;
		hdl = longint'(hd);
		case (ph)
			PH_DRIVE: begin
				dx  = longint'(goal_x_q) - longint'(px);
				dy  = longint'(goal_y_q) - longint'(py);
				d2  = dx * dx + dy * dy;
				tsq = longint'(tol_q) * longint'(tol_q);
				if (d2 <= tsq) begin
					c.ang = SPIN_RATE;
					c.ph  = PH_ALIGN;
				end else begin
					half  = int_sqrt(d2) >> 1;
					c.lin = (half > 32767) ? 16'sh7fff : half[CMD_W-1:0];
					c.ang = clamp16(4 * (goal_bearing(dx, dy) - hdl));
					c.ph  = PH_DRIVE;
				end
			end
			PH_ALIGN: begin
				if (hdl <= longint'(thr_q)) begin
					c.ph = PH_DONE;
				end else begin
					c.ang = SPIN_RATE;
					c.ph  = PH_ALIGN;
				end
			end
			default: c.ph = PH_DONE;
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q = '0;
			goal_y_q = '0;
			tol_q    = 15'd10;
			thr_q    = 16'sd102;
			phase_q  = PH_DRIVE;
			cmd_expected.delete();
			pending  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_GOAL_X: begin
						goal_x_q = cfg_data;
						phase_q  = PH_DRIVE;
					end
					REG_GOAL_Y: begin
						goal_y_q = cfg_data;
						phase_q  = PH_DRIVE;
					end
					REG_TOL: tol_q = cfg_data[TOL_W-1:0];
					REG_THR: thr_q = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (cmd_expected.size() == 0) begin
					report_mismatch("command transaction with no pose pending",
						longint'(linear_cmd), 64'sd0);
				end else begin
					want = cmd_expected.pop_front();
					if (linear_cmd !== want.lin)
						report_mismatch("linear_cmd", longint'(linear_cmd),
							longint'(want.lin));
					if (angular_cmd !== want.ang)
						report_mismatch("angular_cmd", longint'(angular_cmd),
							longint'(want.ang));
					if (phase_now !== want.ph)
						report_mismatch("phase_now", longint'(phase_now), longint'(want.ph));
				end
			end
			if (in_valid && in_ready) begin
				fresh   = next_command(phase_q, pose_x, pose_y, pose_heading);
				phase_q = fresh.ph;
				cmd_expected.push_back(fresh);
			end
			pending <= cmd_expected.size();
		end
	end

endmodule

// File: tb/go_to_goal_pose_controller_core_tb.sv
module go_to_goal_pose_controller_core_tb import ggpc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 1530;
	localparam int HOLD_CYCLES  = 250;
	localparam int LIMIT_CYCLES = 600000;
	localparam int IDLE_PCT     = 36;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [1:0]              cfg_index;
	logic [POS_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [POS_W-1:0] pose_x;
	logic signed [POS_W-1:0] pose_y;
	logic signed [HD_W-1:0]  pose_heading;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [CMD_W-1:0] linear_cmd;
	logic signed [CMD_W-1:0] angular_cmd;
	logic [1:0]              phase_now;
	int                      fail_count;
	int                      pending;

	int                      hold_seq = 0;
	bit                      quiet = 1'b0;
	logic signed [POS_W-1:0] gx_now;
	logic signed [POS_W-1:0] gy_now;
	logic [TOL_W-1:0]        tol_now;

	go_to_goal_pose_controller_core u_top (.*);

	pose_cmd_checker u_check (.*);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("go_to_goal_pose_controller_core verification failed");
		$finish;
	end

	// receiver: random stalls, quiet stretch, one long hold-off
	initial begin
		int last_hold;
		last_hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != last_hold) begin
				last_hold = hold_seq;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// valid stays high after each transaction; random idle gaps (off when quiet) and the caller lower it
	task automatic send_pose(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [HD_W-1:0] hd);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pose_x       <= px;
		pose_y       <= py;
		pose_heading <= hd;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [POS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int                      sent;
		int                      phase_no;
		int                      count;
		int                      sel;
		int                      reach;
		logic signed [POS_W-1:0] thr;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [HD_W-1:0]  hd;

		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_GOAL_X;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		pose_x       <= '0;
		pose_y       <= '0;
		pose_heading <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: goal at origin, tolerance 10, threshold 102
		send_pose(16'sh7fff, 16'sh7fff, 13'sd3217);
		send_pose(16'sh8000, 16'sh8000, -13'sd3217);
		send_pose(16'sh8000, 16'sd0, 13'sd0);
		send_pose(16'sh7fff, 16'sd0, 13'sd1000);
		send_pose(16'sd0, 16'sh8000, -13'sd1);
		send_pose(16'sd0, 16'sh7fff, 13'sd1);
		send_pose(16'sd3, -16'sd4, 13'sd2000);
		send_pose(16'sd0, 16'sd0, 13'sd3217);
		send_pose(16'sd0, 16'sd0, 13'sd102);
		send_pose(16'sd1234, -16'sd999, -13'sd3217);
		drain();

		// zero tolerance, lowest threshold, goal in a far corner
		write_reg(REG_TOL, 16'h8000);
		write_reg(REG_THR, 16'h8000);
		write_reg(REG_GOAL_X, 16'h8000);
		write_reg(REG_GOAL_Y, 16'h7fff);
		cfg_valid <= 1'b0;
		send_pose(16'sh7fff, 16'sh8000, -13'sd3217);
		send_pose(16'sh8000, 16'sh7ffe, 13'sd0);
		send_pose(16'sh8000, 16'sh7fff, 13'sd0);
		send_pose(16'sd0, 16'sd0, -13'sd3217);
		drain();

		// widest tolerance, highest threshold, restart through goal_y alone
		write_reg(REG_TOL, 16'h7fff);
		write_reg(REG_THR, 16'h7fff);
		write_reg(REG_GOAL_Y, 16'h0000);
		cfg_valid <= 1'b0;
		send_pose(16'sd0, 16'sd0, 13'sd5);
		send_pose(-16'sd32668, 16'sd0, 13'sd0);
		send_pose(16'sd0, 16'sd0, 13'sd3217);
		send_pose(16'sd0, 16'sd0, 13'sd0);

		gx_now   = 16'sh8000;
		gy_now   = '0;
		tol_now  = 15'h7fff;
		sent     = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			sel = $urandom_range(0, 9);
			case (sel)
				0: tol_now = '0;
				1: tol_now = 15'h7fff;
				default: tol_now = TOL_W'($urandom_range(0, 3000));
			endcase
			write_reg(REG_TOL, {1'($urandom), tol_now});
			sel = $urandom_range(0, 9);
			case (sel)
				0: thr = 16'sh8000;
				1: thr = 16'sh7fff;
				default: thr = POS_W'(int'($urandom_range(0, 6600)) - 3300);
			endcase
			write_reg(REG_THR, thr);
			if ($urandom_range(0, 1)) begin
				gx_now = POS_W'($urandom);
				write_reg(REG_GOAL_X, gx_now);
			end
			gy_now = POS_W'($urandom);
			write_reg(REG_GOAL_Y, gy_now);
			cfg_valid <= 1'b0;
			if (phase_no == 2) begin
				hold_seq <= hold_seq + 1;
			end
			if (phase_no == 4) begin
				quiet <= 1'b1;
			end
			if (phase_no == 8) begin
				quiet <= 1'b0;
			end

			count = $urandom_range(10, 60);
			repeat (count) begin
				sel = $urandom_range(0, 99);
				if (sel < 35) begin
					reach = (int'(tol_now) * 7) / 10;
				end else if (sel < 85) begin
					reach = int'(tol_now) * 3 + 300;
				end else begin
					reach = -1;
				end
				if (reach < 0) begin
					px = POS_W'($urandom);
					py = POS_W'($urandom);
				end else begin
					px = POS_W'(int'(gx_now) + int'($urandom_range(0, 2 * reach)) - reach);
					py = POS_W'(int'(gy_now) + int'($urandom_range(0, 2 * reach)) - reach);
				end
				if (sel % 8 == 0) begin
					hd = $urandom_range(0, 1) ? 13'sd3217 : -13'sd3217;
				end else begin
					hd = HD_W'(int'($urandom_range(0, 6434)) - 3217);
				end
				send_pose(px, py, hd);
			end
			sent += count;
			phase_no++;
		end

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("go_to_goal_pose_controller_core verification clean");
		end else begin
			$display("go_to_goal_pose_controller_core verification failed");
		end
		$finish;
	end

endmodule
